>>> src/tss_pkg.sv
// Shared constants, codes and interface types of the timed segment sequencer.
package tss_pkg;

    // Queue and tick configuration
    localparam int QUEUE_DEPTH = 16;
    localparam int TICK_RATE   = 60;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal unit widths: divisor TICK_RATE*factor, dividend 2^24 + divisor/2
    localparam int FACTOR_W = 16;
    localparam int D_W      = FACTOR_W + $clog2(TICK_RATE + 1);
    localparam int ONE_POS  = 24;
    localparam int NUM_W    = ((D_W > ONE_POS) ? D_W : ONE_POS) + 2;
    localparam int DCNT_W   = $clog2(NUM_W + 1);

    localparam int TIME_W = 32;
    localparam int DUR_W  = 31;
    localparam int ID_W   = 8;

    // Input operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_END    = 2'd0;
    localparam logic [1:0] KIND_ACTION = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // Configuration register indexes
    localparam logic REG_FINISH_EN = 1'b0;

    // Optional event: valid flag and identifier
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } event_t;

    // One queue entry as stored in the segment memory
    typedef struct packed {
        logic [TIME_W-1:0] left;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] step;
        event_t            action;
        event_t            end_event;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       push_write;
        logic       wb_write;
        logic       set_run;
        logic       clr_run;
        logic       pop;
        logic       latch_end;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       running;
        logic       empty;
        logic       full;
        logic       count_one;
        logic       expired;
        logic       end_valid;
        logic       act_valid;
        logic       held_end_valid;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

>>> src/tss_ram.sv
// Generic single write port, single registered read port RAM.
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/tss_recip.sv
// Bit-serial restoring divider that computes the per-tick step of a segment.
module tss_recip
    import tss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [FACTOR_W-1:0] factor,
    output logic                done,
    output logic [TIME_W-1:0]   step
);

    logic [D_W-1:0]    d_val;
    logic [NUM_W-1:0]  num_val;
    logic [D_W-1:0]    d_reg;
    logic [D_W-1:0]    rem_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [D_W:0]      trial;
    logic              q_bit;
    logic [D_W-1:0]    rem_next;

    // Divisor TICK_RATE * factor with zero raised to one, dividend 2^24 + divisor/2
    always_comb begin
        d_val   = D_W'(TICK_RATE) * ((factor == '0) ? D_W'(1) : D_W'(factor));
        num_val = (NUM_W'(1) << ONE_POS) + NUM_W'(d_val >> 1);
    end

    // One quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, q_reg[NUM_W-1]};
        q_bit    = (trial >= {1'b0, d_reg});
        rem_next = q_bit ? D_W'(trial - {1'b0, d_reg}) : D_W'(trial);
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg   <= d_val;
            rem_reg <= '0;
            q_reg   <= num_val;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NUM_W-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign step = TIME_W'(q_reg);

endmodule

>>> src/tss_datapath.sv
// Datapath: input capture, queue pointers, segment memory, step unit and result register.
module tss_datapath
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [1:0]        s_op,
    input  logic [DUR_W-1:0]  s_duration,
    input  logic [15:0]       s_slowdown,
    input  logic              s_has_action,
    input  logic [ID_W-1:0]   s_action_id,
    input  logic              s_has_end_event,
    input  logic [ID_W-1:0]   s_end_event_id,
    input  logic              s_has_start_time,
    input  logic [TIME_W-1:0] s_start_time,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [ID_W-1:0]   m_event_id,
    output logic [TIME_W-1:0] m_seg_time,
    output logic              m_last
);

    // Captured input transfer
    logic [1:0]        op_reg;
    logic [DUR_W-1:0]  duration_reg;
    logic [15:0]       slowdown_reg;
    event_t            action_reg;
    event_t            end_event_reg;
    logic              has_start_reg;
    logic [TIME_W-1:0] start_time_reg;

    // Queue control state
    logic             running_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    event_t           end_hold_reg;

    // Result register
    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [ID_W-1:0]   m_event_id_reg;
    logic [TIME_W-1:0] m_seg_time_reg;
    logic              m_last_reg;

    logic              div_done;
    logic [TIME_W-1:0] div_step;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_inc;
    entry_t            rd_entry;
    entry_t            new_entry;
    entry_t            wb_entry;
    entry_t            wr_entry;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic              out_free;
    logic [ID_W-1:0]   emit_id;
    logic [TIME_W-1:0] emit_time;

    tss_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .factor  (slowdown_reg),
        .done    (div_done),
        .step    (div_step)
    );

    // Capture the accepted input transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= s_op;
            duration_reg   <= s_duration;
            slowdown_reg   <= s_slowdown;
            action_reg     <= '{valid: s_has_action, id: s_action_id};
            end_event_reg  <= '{valid: s_has_end_event, id: s_end_event_id};
            has_start_reg  <= s_has_start_time;
            start_time_reg <= s_start_time;
        end
    end

    // Tail slot and next head, wrapped at the queue depth
    always_comb begin
        tail_sum = (PTR_W+1)'(head_reg) + (PTR_W+1)'(count_reg);
        if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            tail = PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH));
        end else begin
            tail = PTR_W'(tail_sum);
        end
        head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(head_reg + 1'b1);
    end

    // Run flag, head pointer and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            head_reg    <= '0;
            count_reg   <= '0;
        end else begin
            if (cmd.set_run) begin
                running_reg <= 1'b1;
            end else if (cmd.clr_run) begin
                running_reg <= 1'b0;
            end
            if (cmd.pop) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end else if (cmd.push_write) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Build new and updated entries
    always_comb begin
        new_entry.left      = {1'b0, duration_reg};
        new_entry.elapsed   = (has_start_reg && !running_reg) ? start_time_reg : '0;
        new_entry.step      = div_step;
        new_entry.action    = action_reg.valid ? action_reg : '0;
        new_entry.end_event = end_event_reg.valid ? end_event_reg : '0;

        wb_entry         = rd_entry;
        wb_entry.left    = rd_entry.left - rd_entry.step;
        wb_entry.elapsed = rd_entry.elapsed + rd_entry.step;

        ram_we    = cmd.push_write || cmd.wb_write;
        ram_waddr = cmd.push_write ? tail : head_reg;
        wr_entry  = cmd.push_write ? new_entry : wb_entry;
    end

    tss_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (head_reg),
        .rdata (rd_entry)
    );

    // Hold the end event of the popped segment
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_hold_reg <= '0;
        end else if (cmd.latch_end) begin
            end_hold_reg <= rd_entry.end_event;
        end
    end

    // Select result payload by kind
    always_comb begin
        case (cmd.emit_kind)
            KIND_END: begin
                emit_id   = end_hold_reg.id;
                emit_time = '0;
            end
            KIND_ACTION: begin
                emit_id   = rd_entry.action.id;
                emit_time = rd_entry.elapsed;
            end
            default: begin
                emit_id   = '0;
                emit_time = '0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    // Result register: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg     <= cmd.emit_kind;
            m_event_id_reg <= emit_id;
            m_seg_time_reg <= emit_time;
            m_last_reg     <= cmd.emit_last;
        end
    end

    // Status toward the controller
    always_comb begin
        sts.op             = op_reg;
        sts.running        = running_reg;
        sts.empty          = (count_reg == '0);
        sts.full           = (count_reg >= CNT_W'(QUEUE_DEPTH));
        sts.count_one      = (count_reg == CNT_W'(1));
        sts.expired        = (rd_entry.left == '0) || rd_entry.left[TIME_W-1];
        sts.end_valid      = rd_entry.end_event.valid;
        sts.act_valid      = rd_entry.action.valid;
        sts.held_end_valid = end_hold_reg.valid;
        sts.div_done       = div_done;
        sts.out_free       = out_free;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_event_id = m_event_id_reg;
    assign m_seg_time = m_seg_time_reg;
    assign m_last     = m_last_reg;

endmodule

>>> src/tss_ctrl.sv
// Controller state machine that sequences pushes, starts and ticks.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic finish_en,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_RD,
        S_CHK,
        S_POPRD,
        S_END,
        S_ACT,
        S_REJECT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   more_reg;
    logic   more_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        more_next  = more_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.op)
                    OP_PUSH: begin
                        if (sts.full) begin
                            state_next = S_REJECT;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_START: begin
                        cmd.set_run = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_TICK: begin
                        if (!sts.running) begin
                            state_next = S_IDLE;
                        end else if (sts.empty) begin
                            cmd.clr_run = 1'b1;
                            state_next  = finish_en ? S_FINISH : S_IDLE;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.push_write = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                // Pop an expired head; otherwise advance it
                if (sts.expired) begin
                    cmd.latch_end = 1'b1;
                    cmd.pop       = 1'b1;
                    if (sts.count_one) begin
                        more_next  = 1'b0;
                        state_next = sts.end_valid ? S_END : S_IDLE;
                    end else begin
                        more_next  = 1'b1;
                        state_next = S_POPRD;
                    end
                end else begin
                    state_next = S_ACT;
                end
            end
            S_POPRD: begin
                state_next = S_END;
            end
            S_END: begin
                if (!sts.held_end_valid) begin
                    state_next = S_ACT;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_END;
                    cmd.emit_last = !more_reg || !sts.act_valid;
                    state_next    = more_reg ? S_ACT : S_IDLE;
                end
            end
            S_ACT: begin
                if (!sts.act_valid) begin
                    cmd.wb_write = 1'b1;
                    state_next   = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ACTION;
                    cmd.emit_last = 1'b1;
                    cmd.wb_write  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_REJECT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_REJECT;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_FINISH;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and follow-on flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            more_reg  <= more_next;
        end
    end

endmodule

>>> src/timed_segment_sequencer_unit.sv
// Top level of the timed segment sequencer: register port, controller and datapath.
//
//   channel   ports          direction  handshake
//   input     s_*            in         s_valid / s_ready
//   result    m_*            out        m_valid / m_ready
//   config    p* (APB)       in/out     psel, penable, pwrite, pready
//
// A start or an ignored op is done after decode; a rejected push also emits its reject
// result. A tick reads the head segment through the registered segment memory, plus a
// second read when a segment is popped and another one follows it.
// A push waits for the one-bit-per-cycle step divider. Results leave through a one-entry
// output register; the next input is taken while it waits, and emission holds while the
// register is occupied and m_ready is low.
// Reset clears run flag, pointers and count; segment memory is not cleared.
module timed_segment_sequencer_unit
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [DUR_W-1:0]  s_duration,
    input  logic [15:0]       s_slowdown,
    input  logic              s_has_action,
    input  logic [ID_W-1:0]   s_action_id,
    input  logic              s_has_end_event,
    input  logic [ID_W-1:0]   s_end_event_id,
    input  logic              s_has_start_time,
    input  logic [TIME_W-1:0] s_start_time,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [ID_W-1:0]   m_event_id,
    output logic [TIME_W-1:0] m_seg_time,
    output logic              m_last,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic finish_en_reg;
    logic reg_idx;
    logic cfg_write;
    cmd_t cmd;
    sts_t sts;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Finish notice enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finish_en_reg <= 1'b0;
        end else if (cfg_write && (reg_idx == REG_FINISH_EN)) begin
            finish_en_reg <= pwdata[0];
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            REG_FINISH_EN: prdata = {31'd0, finish_en_reg};
            default:       prdata = '0;
        endcase
    end

    tss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .finish_en (finish_en_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    tss_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_op             (s_op),
        .s_duration       (s_duration),
        .s_slowdown       (s_slowdown),
        .s_has_action     (s_has_action),
        .s_action_id      (s_action_id),
        .s_has_end_event  (s_has_end_event),
        .s_end_event_id   (s_end_event_id),
        .s_has_start_time (s_has_start_time),
        .s_start_time     (s_start_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_event_id       (m_event_id),
        .m_seg_time       (m_seg_time),
        .m_last           (m_last)
    );

`ifndef SYNTHESIS
    // Never overwrite a result that has not been transferred
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result emitted while output register is occupied");

    // Never write a new segment into a full queue
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_write |-> !sts.full)
        else $error("segment written into a full queue");

    // A full queue is never empty
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.full && sts.empty))
        else $error("fill count inconsistent");

    // No result is emitted and no segment popped while waiting for an input transfer
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.emit && !cmd.pop)
        else $error("datapath activity while idle");
`endif

endmodule

>>> bench/timed_segment_sequencer_unit_tb.sv
// Self-checking testbench for the timed segment sequencer: directed table, then paced random traffic.
module timed_segment_sequencer_unit_tb;
    import tss_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         PREDICT    = -1;
    localparam int         SETTLE     = 40;
    localparam int         CYCLE_LIMIT = 400000;

    // One input transfer
    typedef struct packed {
        logic [1:0]        op;
        logic [DUR_W-1:0]  duration;
        logic [15:0]       slowdown;
        logic              has_action;
        logic [ID_W-1:0]   action_id;
        logic              has_end_event;
        logic [ID_W-1:0]   end_event_id;
        logic              has_start_time;
        logic [TIME_W-1:0] start_time;
    } seg_cmd_t;

    // One result transfer
    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] seg_time;
        logic              last;
    } seg_result_t;

    // Directed row: command, repeat count, typed results or PREDICT
    typedef struct {
        seg_cmd_t    cmd;
        int          reps;
        int          n_typed;
        seg_result_t r0;
        seg_result_t r1;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_op;
    logic [DUR_W-1:0]  s_duration;
    logic [15:0]       s_slowdown;
    logic              s_has_action;
    logic [ID_W-1:0]   s_action_id;
    logic              s_has_end_event;
    logic [ID_W-1:0]   s_end_event_id;
    logic              s_has_start_time;
    logic [TIME_W-1:0] s_start_time;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_kind;
    logic [ID_W-1:0]   m_event_id;
    logic [TIME_W-1:0] m_seg_time;
    logic              m_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted sequencer state
    bit          notice_en;
    bit          run_flag;
    int          q_head;
    int          q_count;
    logic [31:0] q_left    [QUEUE_DEPTH];
    logic [31:0] q_elapsed [QUEUE_DEPTH];
    logic [31:0] q_step    [QUEUE_DEPTH];
    logic [8:0]  q_action  [QUEUE_DEPTH];
    logic [8:0]  q_end     [QUEUE_DEPTH];

    seg_result_t expected_q[$];
    stim_row_t   directed_rows[$];

    int errors;
    int transfers_in;
    int results_checked;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;
    int cycle_count;

    timed_segment_sequencer_unit DUT (.*);

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Step of one tick: 1/(TICK_RATE*factor) in Q8.24, rounded half up
    function automatic logic [31:0] step_for(input logic [15:0] f);
        logic [63:0] d;
        d = 64'(TICK_RATE) * ((f == 16'd0) ? 64'd1 : 64'(f));
        return 32'(((64'd1 << 24) + d / 2) / d);
    endfunction

    function automatic seg_result_t result_of(input logic [1:0] kind,
                                              input logic [ID_W-1:0] id,
                                              input logic [TIME_W-1:0] t,
                                              input logic last);
        seg_result_t r;
        r.kind     = kind;
        r.event_id = id;
        r.seg_time = t;
        r.last     = last;
        return r;
    endfunction

    function automatic seg_cmd_t op_only(input logic [1:0] op);
        seg_cmd_t c;
        c    = '0;
        c.op = op;
        return c;
    endfunction

    function automatic seg_cmd_t push_seg(input logic [DUR_W-1:0] dur, input logic [15:0] f,
                                          input logic ha, input logic [7:0] aid,
                                          input logic he, input logic [7:0] eid,
                                          input logic hs, input logic [31:0] st);
        seg_cmd_t c;
        c.op             = OP_PUSH;
        c.duration       = dur;
        c.slowdown       = f;
        c.has_action     = ha;
        c.action_id      = aid;
        c.has_end_event  = he;
        c.end_event_id   = eid;
        c.has_start_time = hs;
        c.start_time     = st;
        return c;
    endfunction

    // Random command: mostly pushes and ticks, some starts and unused ops
    function automatic seg_cmd_t random_cmd();
        seg_cmd_t c;
        int pick;
        int sel;
        c.duration       = DUR_W'($urandom);
        c.has_action     = ($urandom_range(0, 3) != 0);
        c.action_id      = ID_W'($urandom);
        c.has_end_event  = 1'($urandom_range(0, 1));
        c.end_event_id   = ID_W'($urandom);
        c.has_start_time = 1'($urandom_range(0, 1));
        c.start_time     = TIME_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            c.slowdown = 16'd0;
        else if (sel == 1)
            c.slowdown = 16'hFFFF;
        else if (sel == 2)
            c.slowdown = 16'($urandom);
        else
            c.slowdown = 16'($urandom_range(16, 1024));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            c.op = OP_PUSH;
        else if (pick < 33)
            c.op = OP_START;
        else if (pick < 96)
            c.op = OP_TICK;
        else
            c.op = OP_UNUSED;
        // keep queued segments short-lived; a full queue takes any duration
        if (c.op == OP_PUSH && q_count < QUEUE_DEPTH)
            c.duration = DUR_W'($urandom_range(0, 4 * step_for(c.slowdown)));
        return c;
    endfunction

    // Advance the predicted state by one accepted command
    task automatic advance_model(input seg_cmd_t c, input bit keep);
        seg_result_t out_q[$];
        int slot;
        int h;
        bit expired;
        case (c.op)
            OP_PUSH: begin
                if (q_count >= QUEUE_DEPTH) begin
                    out_q.push_back(result_of(KIND_REJECT, '0, '0, 1'b0));
                end else begin
                    slot = (q_head + q_count) % QUEUE_DEPTH;
                    q_left[slot]    = {1'b0, c.duration};
                    q_step[slot]    = step_for(c.slowdown);
                    q_action[slot]  = {c.has_action, c.action_id};
                    q_end[slot]     = {c.has_end_event, c.end_event_id};
                    q_elapsed[slot] = (c.has_start_time && !run_flag) ? c.start_time : '0;
                    q_count++;
                end
            end
            OP_START: run_flag = 1'b1;
            OP_TICK: begin
                if (run_flag && q_count == 0) begin
                    if (notice_en)
                        out_q.push_back(result_of(KIND_FINISH, '0, '0, 1'b0));
                    run_flag = 1'b0;
                end else if (run_flag) begin
                    h       = q_head;
                    expired = (q_left[h] == '0) || q_left[h][31];
                    // pop an expired head, firing its end event
                    if (expired) begin
                        if (q_end[h][8])
                            out_q.push_back(result_of(KIND_END, q_end[h][7:0], '0, 1'b0));
                        q_head = (h + 1) % QUEUE_DEPTH;
                        q_count--;
                        h = q_head;
                    end
                    // emit the action and advance, unless the queue just emptied
                    if (!expired || q_count != 0) begin
                        if (q_action[h][8])
                            out_q.push_back(result_of(KIND_ACTION, q_action[h][7:0],
                                                      q_elapsed[h], 1'b0));
                        q_left[h]    = q_left[h] - q_step[h];
                        q_elapsed[h] = q_elapsed[h] + q_step[h];
                    end
                end
            end
            default: ;
        endcase
        if (out_q.size() > 0)
            out_q[out_q.size() - 1].last = 1'b1;
        if (keep)
            foreach (out_q[i])
                expected_q.push_back(out_q[i]);
    endtask

    task automatic add_row(input seg_cmd_t c, input int reps, input int n,
                           input seg_result_t a = '0, input seg_result_t b = '0);
        stim_row_t row;
        row.cmd     = c;
        row.reps    = reps;
        row.n_typed = n;
        row.r0      = a;
        row.r1      = b;
        directed_rows.push_back(row);
    endtask

    // Offer one command and hold it until the transfer
    task automatic send_cmd(input seg_cmd_t c);
        s_valid          <= 1'b1;
        s_op             <= c.op;
        s_duration       <= c.duration;
        s_slowdown       <= c.slowdown;
        s_has_action     <= c.has_action;
        s_action_id      <= c.action_id;
        s_has_end_event  <= c.has_end_event;
        s_end_event_id   <= c.end_event_id;
        s_has_start_time <= c.has_start_time;
        s_start_time     <= c.start_time;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        transfers_in++;
    endtask

    // Drop valid at the current idle rate
    task automatic pace();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge aclk);
        end
    endtask

    // Wait until every expected result has come, then let a push finish
    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE)
            @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Write the finish notice enable and read it back
    task automatic write_notice(input bit v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_FINISH_EN, 2'b00};
        pwdata  <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        notice_en = v;
        @(posedge aclk);
        check_field("prdata", {31'd0, v}, prdata);
        check_field("pready", 32'd1, 32'(pready));
    endtask

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        seg_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d id %h time %h last %b",
                         $time, m_kind, m_event_id, m_seg_time, m_last);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("event_id", 32'(want.event_id), 32'(m_event_id));
                check_field("seg_time", want.seg_time, m_seg_time);
                check_field("last", 32'(want.last), 32'(m_last));
                results_checked++;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial begin
        int idle_tab   [5];
        int stall_tab  [5];
        int notice_tab [5];
        int items_tab  [5];
        seg_cmd_t c;
        idle_tab   = '{0, 49, 0, 34, 0};
        stall_tab  = '{0, 0, 49, 34, 0};
        notice_tab = '{0, 1, 0, 1, 1};
        items_tab  = '{320, 320, 320, 320, 60};

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_op             <= OP_TICK;
        s_duration       <= '0;
        s_slowdown       <= '0;
        s_has_action     <= 1'b0;
        s_action_id      <= '0;
        s_has_end_event  <= 1'b0;
        s_end_event_id   <= '0;
        s_has_start_time <= 1'b0;
        s_start_time     <= '0;
        m_ready          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        // Build the directed table
        add_row(op_only(OP_TICK), 1, 0);
        add_row(op_only(OP_UNUSED), 1, 0);
        add_row(op_only(OP_START), 1, 0);
        add_row(op_only(OP_TICK), 1, 1, result_of(KIND_FINISH, '0, '0, 1'b1));
        add_row(push_seg(31'd1, 16'd0, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b1, 32'hFFFF_FFFF), 1, 0);
        add_row(push_seg(31'd8, 16'hFFFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 32'h0), 1, 0);
        add_row(op_only(OP_START), 1, 0);
        add_row(op_only(OP_TICK), 1, 1, result_of(KIND_ACTION, 8'hFF, 32'hFFFF_FFFF, 1'b1));
        add_row(op_only(OP_TICK), 1, 2, result_of(KIND_END, 8'h00, '0, 1'b0),
                result_of(KIND_ACTION, 8'h00, '0, 1'b1));
        add_row(push_seg(31'h10000, 16'h0100, 1'b1, 8'h5A, 1'b1, 8'hA5, 1'b1, 32'h1234_5678),
                1, PREDICT);
        add_row(push_seg(31'h40, 16'h0080, 1'b0, 8'h00, 1'b1, 8'h3C, 1'b0, 32'h0), 14, PREDICT);
        add_row(push_seg(31'h7FFF_FFFF, 16'h0100, 1'b1, 8'h11, 1'b1, 8'h22, 1'b1,
                         32'hFFFF_FFFF), 1, 1, result_of(KIND_REJECT, '0, '0, 1'b1));
        add_row(op_only(OP_START), 1, PREDICT);
        add_row(op_only(OP_TICK), 80, PREDICT);

        // Reset
        repeat (2)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, finish notice on
        write_notice(1'b1);
        foreach (directed_rows[i]) begin
            repeat (directed_rows[i].reps) begin
                send_cmd(directed_rows[i].cmd);
                advance_model(directed_rows[i].cmd, directed_rows[i].n_typed == PREDICT);
                if (directed_rows[i].n_typed > 0)
                    expected_q.push_back(directed_rows[i].r0);
                if (directed_rows[i].n_typed > 1)
                    expected_q.push_back(directed_rows[i].r1);
            end
        end
        s_valid <= 1'b0;

        // Random phases at different pacing; the last one holds the receiver off
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_notice(notice_tab[ph] != 0);
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 4)
                hold_req = 600;
            repeat (items_tab[ph]) begin
                c = random_cmd();
                send_cmd(c);
                advance_model(c, 1'b1);
                pace();
            end
            s_valid <= 1'b0;
        end

        drain();
        $display("covered %0d input transfers and %0d checked results over five pacing phases,",
                 transfers_in, results_checked);
        $display("with the finish notice both off and on and one long output hold-off");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/tss_pkg.sv
src/tss_ram.sv
src/tss_recip.sv
src/tss_datapath.sv
src/tss_ctrl.sv
src/timed_segment_sequencer_unit.sv
bench/timed_segment_sequencer_unit_tb.sv
